>>> src/cseu_pkg.sv
// Shared types, constants and the escape table for the capability string unescape unit.
package cseu_pkg;

  // Character codes
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChCaret     = 8'h5E;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] CtrlMask    = 8'h1F;

  // Default depth of the queue between decoder and emitter
  localparam int unsigned QueueDepthDefault = 4;

  // Decoder mode, one-hot
  typedef enum logic [3:0] {
    MODE_PLAIN  = 4'b0001,
    MODE_CARET  = 4'b0010,
    MODE_BSLASH = 4'b0100,
    MODE_OCTAL  = 4'b1000
  } mode_t;

  // One decoded result
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } result_t;

  // All results caused by one input byte (one or two)
  typedef struct packed {
    result_t first;
    logic    has_second;
    result_t second;
  } entry_t;

  // Named backslash escape lookup
  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } esc_hit_t;

  function automatic esc_hit_t esc_lookup(input logic [7:0] c);
    esc_hit_t r;
    r.hit   = 1'b1;
    r.value = c;
    case (c)
      8'h45:   r.value = 8'h1B;  // E -> ESC
      8'h5E:   r.value = 8'h5E;  // ^
      8'h5C:   r.value = 8'h5C;  // backslash
      8'h3A:   r.value = 8'h3A;  // colon
      8'h6E:   r.value = 8'h0A;  // n -> LF
      8'h72:   r.value = 8'h0D;  // r -> CR
      8'h74:   r.value = 8'h09;  // t -> TAB
      8'h62:   r.value = 8'h08;  // b -> BS
      8'h66:   r.value = 8'h0C;  // f -> FF
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> src/cseu_ifs.sv
// Valid/ready channel interfaces for raw input bytes and decoded results.
interface cseu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface cseu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_field;
  modport source (output valid, output out_byte, output end_of_field, input ready);
  modport sink (input valid, input out_byte, input end_of_field, output ready);
endinterface

>>> src/cseu_front.sv
// Front end: accepts raw bytes, tracks escape mode and builds queue entries.
module cseu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            q_full,
  output logic            push,
  output cseu_pkg::entry_t push_entry
);
  import cseu_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [9:0]  acc_r, acc_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic        take;
  logic        is_digit;
  logic [3:0]  digit_val;
  logic [9:0]  acc_shift;
  esc_hit_t    esc;
  result_t     plain_res;
  logic        plain_emits;
  mode_t       plain_mode;
  entry_t      ent;
  logic        emit;

  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;
  assign is_digit  = (in_byte >= ChZero) && (in_byte <= ChNine);
  assign digit_val = 4'(in_byte - ChZero);
  assign acc_shift = {acc_r[6:0], 3'b000} | {6'b0, digit_val};
  assign esc       = esc_lookup(in_byte);

  // Classify a byte seen in plain mode
  always_comb begin
    plain_res.data = in_byte;
    plain_res.eof  = 1'b0;
    plain_emits    = 1'b1;
    plain_mode     = MODE_PLAIN;
    if (in_byte == ChColon || in_byte == ChNul) begin
      plain_res.data = 8'h00;
      plain_res.eof  = 1'b1;
    end else if (in_byte == ChCaret) begin
      plain_emits = 1'b0;
      plain_mode  = MODE_CARET;
    end else if (in_byte == ChBackslash) begin
      plain_emits = 1'b0;
      plain_mode  = MODE_BSLASH;
    end
  end

  // Decode one byte against the current mode
  always_comb begin
    mode_nxt       = mode_r;
    acc_nxt        = acc_r;
    digits_nxt     = digits_r;
    emit           = 1'b0;
    ent.first      = plain_res;
    ent.has_second = 1'b0;
    ent.second     = plain_res;
    case (mode_r)
      MODE_CARET: begin
        mode_nxt = MODE_PLAIN;
        emit     = 1'b1;
        if (in_byte == ChNul) begin
          ent.first.data = 8'h00;
          ent.first.eof  = 1'b1;
        end else begin
          ent.first.data = in_byte & CtrlMask;
          ent.first.eof  = 1'b0;
        end
      end
      MODE_BSLASH: begin
        mode_nxt      = MODE_PLAIN;
        emit          = 1'b1;
        ent.first.eof = 1'b0;
        if (in_byte == ChNul) begin
          ent.first.data = 8'h00;
          ent.first.eof  = 1'b1;
        end else if (esc.hit) begin
          ent.first.data = esc.value;
        end else if (is_digit) begin
          emit       = 1'b0;
          mode_nxt   = MODE_OCTAL;
          acc_nxt    = {6'b0, digit_val};
          digits_nxt = 2'd1;
        end else begin
          ent.first.data = in_byte;
        end
      end
      MODE_OCTAL: begin
        if (is_digit) begin
          if (digits_r == 2'd2) begin
            emit           = 1'b1;
            ent.first.data = acc_shift[7:0];
            ent.first.eof  = 1'b0;
            mode_nxt       = MODE_PLAIN;
            acc_nxt        = '0;
            digits_nxt     = '0;
          end else begin
            acc_nxt    = acc_shift;
            digits_nxt = digits_r + 2'd1;
          end
        end else begin
          // Flush the value, then decode this byte in plain mode
          emit           = 1'b1;
          ent.first.data = acc_r[7:0];
          ent.first.eof  = 1'b0;
          ent.has_second = plain_emits;
          ent.second     = plain_res;
          mode_nxt       = plain_mode;
          acc_nxt        = '0;
          digits_nxt     = '0;
        end
      end
      default: begin
        emit      = plain_emits;
        ent.first = plain_res;
        mode_nxt  = plain_mode;
      end
    endcase
  end

  assign push       = take && emit;
  assign push_entry = ent;

  // Advance decoder state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PLAIN;
      acc_r    <= '0;
      digits_r <= '0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      digits_r <= digits_nxt;
    end
  end

  a_digits_only_octal: assert property (@(posedge clk) disable iff (!rst_n)
    (digits_r != 2'd0) |-> (mode_r == MODE_OCTAL))
    else $error("digit count set outside numeric escape");

  a_octal_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_OCTAL) |-> (digits_r == 2'd1 || digits_r == 2'd2))
    else $error("numeric escape with bad digit count");

endmodule

>>> src/cseu_queue.sv
// Short queue of decoded entries between the front end and the emitter.
module cseu_queue #(
  parameter int unsigned DEPTH = cseu_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cseu_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output cseu_pkg::entry_t head
);
  import cseu_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            store_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full    = (count_r == CntW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = store_r[rd_ptr_r];

  // Write entries
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !q_valid))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> src/cseu_back.sv
// Back end: unpacks queue entries into single results behind an output register.
module cseu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cseu_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_eof
);
  import cseu_pkg::*;

  logic    out_valid_r;
  result_t out_r;
  logic    pend_r;
  result_t pend_res_r;
  logic    load;

  assign load      = !out_valid_r || out_ready;
  assign pop       = load && !pend_r && q_valid;
  assign out_valid = out_valid_r;
  assign out_byte  = out_r.data;
  assign out_eof   = out_r.eof;

  // Load the output register from the pending slot or the queue head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= q_valid;
        pend_r      <= q_valid && head.has_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        out_r <= pend_res_r;
      end else if (q_valid) begin
        out_r      <= head.first;
        pend_res_r <= head.second;
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("second result pending with empty output register");

  a_no_pop_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !pop)
    else $error("queue popped while second result pending");

endmodule

>>> src/capability_string_unescape_unit.sv
// Top level of the capability string unescape unit.
//
//  Channel   Direction  Payload                       Transfer when
//  in_chan   in         in_byte[7:0]                  valid && ready
//  out_chan  out        out_byte[7:0], end_of_field   valid && ready
//
// One input byte per cycle is taken while the entry queue has room.
// A result is written to the entry queue and then loaded into the output register.
// A byte that flushes a short numeric escape and yields a second result gives
// both in turn from the emitter's single output register; no entry is popped meanwhile.
// Reset (synchronous, active low) empties the queue and returns to plain mode.
// Input and output stall independently; the queue absorbs the difference.
module capability_string_unescape_unit #(
  parameter int unsigned QUEUE_DEPTH = cseu_pkg::QueueDepthDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  cseu_in_if.sink  in_chan,
  cseu_out_if.source out_chan
);
  import cseu_pkg::*;

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   q_valid;
  entry_t head;

  cseu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_byte    (in_chan.in_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cseu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  cseu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.out_byte),
    .out_eof   (out_chan.end_of_field)
  );

endmodule

>>> verif/capability_string_unescape_unit_tb.sv
// Self-checking testbench for the capability string unescape unit.
`timescale 1ns / 1ps

module capability_string_unescape_unit_tb;
  import cseu_pkg::*;

  localparam int unsigned RandomItems = 650;
  localparam int unsigned HoldCycles  = 48;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned ReportLimit = 10;

  // Letters that name a backslash escape
  localparam logic [7:0] NamedChars [9] = '{"E", "^", "\\", ":", "n", "r", "t", "b", "f"};

  // One directed row; typed rows carry the single result they must produce
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [7:0] want_data;
    logic       want_eof;
  } stim_row_t;

  localparam stim_row_t DirectedRows [26] = '{
    '{8'h41,       1'b1, 8'h41, 1'b0},  // plain byte right after reset
    '{8'hFF,       1'b1, 8'hFF, 1'b0},  // top of the byte range
    '{ChNul,       1'b1, 8'h00, 1'b1},  // NUL ends the field
    '{ChColon,     1'b1, 8'h00, 1'b1},  // colon ends the field
    '{ChCaret,     1'b0, 8'h00, 1'b0},
    '{ChColon,     1'b1, 8'h1A, 1'b0},  // colon after caret stays in the field
    '{ChCaret,     1'b0, 8'h00, 1'b0},
    '{8'hFF,       1'b1, 8'h1F, 1'b0},  // caret masks to five bits
    '{ChCaret,     1'b0, 8'h00, 1'b0},
    '{ChNul,       1'b1, 8'h00, 1'b1},  // NUL after caret ends the field
    '{ChBackslash, 1'b0, 8'h00, 1'b0},
    '{8'h45,       1'b1, 8'h1B, 1'b0},  // backslash E gives escape
    '{ChBackslash, 1'b0, 8'h00, 1'b0},
    '{ChNul,       1'b1, 8'h00, 1'b1},  // NUL after backslash ends the field
    '{ChBackslash, 1'b0, 8'h00, 1'b0},
    '{ChNine,      1'b0, 8'h00, 1'b0},
    '{ChNine,      1'b0, 8'h00, 1'b0},
    '{ChNine,      1'b1, 8'h49, 1'b0},  // third digit emits the truncated value
    '{ChBackslash, 1'b0, 8'h00, 1'b0},
    '{8'h37,       1'b0, 8'h00, 1'b0},
    '{ChColon,     1'b0, 8'h00, 1'b0},  // short escape, then end of field
    '{ChBackslash, 1'b0, 8'h00, 1'b0},
    '{ChZero,      1'b0, 8'h00, 1'b0},
    '{8'h31,       1'b0, 8'h00, 1'b0},
    '{ChBackslash, 1'b0, 8'h00, 1'b0},  // short escape, then a new backslash
    '{8'h71,       1'b1, 8'h71, 1'b0}   // unnamed byte after backslash
  };

  logic clk = 1'b0;
  logic rst_n;

  cseu_in_if  in_chan ();
  cseu_out_if out_chan ();

  capability_string_unescape_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #1 clk = ~clk;

  // Decoder state mirrored on the bench side
  mode_t      cur_mode = MODE_PLAIN;
  logic [9:0] octal_acc = '0;
  logic [1:0] octal_count = '0;

  result_t    step_results [$];
  result_t    pending_q [$];
  logic [7:0] token_bytes [$];

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit is_digit_char(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic bit named_escape(input logic [7:0] c, output logic [7:0] v);
    bit hit;
    hit = 1'b1;
    v   = c;
    case (c)
      "E":     v = 8'h1B;
      "n":     v = 8'h0A;
      "r":     v = 8'h0D;
      "t":     v = 8'h09;
      "b":     v = 8'h08;
      "f":     v = 8'h0C;
      "^", "\\", ":": v = c;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic void emit(input logic [7:0] d, input logic e);
    result_t r;
    r.data = d;
    r.eof  = e;
    step_results.push_back(r);
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    if (c == ChColon || c == ChNul) emit(8'h00, 1'b1);
    else if (c == ChCaret) cur_mode = MODE_CARET;
    else if (c == ChBackslash) cur_mode = MODE_BSLASH;
    else emit(c, 1'b0);
  endfunction

  function automatic void clear_octal();
    cur_mode    = MODE_PLAIN;
    octal_acc   = '0;
    octal_count = '0;
  endfunction

  // Advance the decoder by one byte and collect the bytes it yields
  function automatic void decode_byte(input logic [7:0] c);
    logic [7:0] named;
    step_results.delete();
    case (cur_mode)
      MODE_CARET: begin
        cur_mode = MODE_PLAIN;
        if (c == ChNul) emit(8'h00, 1'b1);
        else emit(c & CtrlMask, 1'b0);
      end
      MODE_BSLASH: begin
        cur_mode = MODE_PLAIN;
        if (c == ChNul) begin
          emit(8'h00, 1'b1);
        end else if (named_escape(c, named)) begin
          emit(named, 1'b0);
        end else if (is_digit_char(c)) begin
          cur_mode    = MODE_OCTAL;
          octal_acc   = 10'(c - ChZero);
          octal_count = 2'd1;
        end else begin
          emit(c, 1'b0);
        end
      end
      MODE_OCTAL: begin
        if (is_digit_char(c)) begin
          octal_acc   = {octal_acc[6:0], 3'b000} | 10'(c - ChZero);
          octal_count = octal_count + 2'd1;
          if (octal_count == 2'd3) begin
            emit(octal_acc[7:0], 1'b0);
            clear_octal();
          end
        end else begin
          // flush the short escape, then decode this byte as plain
          emit(octal_acc[7:0], 1'b0);
          clear_octal();
          take_plain(c);
        end
      end
      default: begin
        cur_mode = MODE_PLAIN;
        take_plain(c);
      end
    endcase
  endfunction

  // Build one random token: mostly plain bytes, escapes and field ends, some noise
  function automatic void build_token();
    int unsigned pick;
    logic [7:0]  c;
    token_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      c = 8'($urandom_range(1, 255));
      if (c == ChColon || c == ChCaret || c == ChBackslash) c = c ^ 8'h20;
      token_bytes.push_back(c);
    end else if (pick < 47) begin
      token_bytes.push_back(ChCaret);
      token_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 62) begin
      token_bytes.push_back(ChBackslash);
      token_bytes.push_back(NamedChars[$urandom_range(0, 8)]);
    end else if (pick < 77) begin
      token_bytes.push_back(ChBackslash);
      repeat ($urandom_range(1, 3)) token_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
    end else if (pick < 85) begin
      token_bytes.push_back($urandom_range(0, 1) ? ChColon : ChNul);
    end else begin
      token_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Offer one byte, wait for its transfer, then queue what it must yield
  task automatic send_byte(input logic [7:0] c, input logic typed,
                           input logic [7:0] want_data, input logic want_eof);
    int unsigned idle;
    result_t     r;
    idle = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (idle != 0) begin
      in_chan.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    decode_byte(c);
    if (typed) begin
      r.data = want_data;
      r.eof  = want_eof;
      pending_q.push_back(r);
    end else begin
      foreach (step_results[i]) pending_q.push_back(step_results[i]);
    end
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= ReportLimit) $display("%s", msg);
  endtask

  // Drop the input valid and hold until every expected byte has come out
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_q.size() == 0) begin
        note_error($sformatf("unexpected result: byte %02h eof %0b",
                             out_chan.out_byte, out_chan.end_of_field));
      end else begin
        want = pending_q.pop_front();
        if (out_chan.out_byte !== want.data || out_chan.end_of_field !== want.eof)
          note_error($sformatf("result mismatch: expected byte %02h eof %0b, got byte %02h eof %0b",
                               want.data, want.eof, out_chan.out_byte, out_chan.end_of_field));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[capability_string_unescape_unit] ERROR");
      $finish;
    end
  end

  // Pace the result sink: random stalls, a long hold-off on request
  initial begin : result_pacing
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_chan.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        if (stall_left != 0) begin
          stall_left--;
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= 1'b1;
        end
      end
    end
  end

  // Reset, directed table, then random tokens
  initial begin : stimulus
    int unsigned sent;
    bit          did_hold;
    bit          did_drain;
    sent      = 0;
    did_hold  = 1'b0;
    did_drain = 1'b0;
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.in_byte = 8'h00;
    out_chan.ready  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DirectedRows[i])
      send_byte(DirectedRows[i].ch, DirectedRows[i].typed,
                DirectedRows[i].want_data, DirectedRows[i].want_eof);

    while (sent < RandomItems) begin
      quiet = ((sent / 80) % 3) == 1;
      // fill the block while the sink holds off
      if (!did_hold && quiet && sent >= 300) begin
        did_hold = 1'b1;
        hold_req = 1'b1;
      end
      // pause the source until the block has emptied
      if (!did_drain && sent >= 480) begin
        did_drain = 1'b1;
        drain_results();
      end
      build_token();
      foreach (token_bytes[j]) begin
        send_byte(token_bytes[j], 1'b0, 8'h00, 1'b0);
        sent++;
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("[capability_string_unescape_unit] OK");
    end else begin
      $display("[capability_string_unescape_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> capability_string_unescape_unit.f
src/cseu_pkg.sv
src/cseu_ifs.sv
src/cseu_front.sv
src/cseu_queue.sv
src/cseu_back.sv
src/capability_string_unescape_unit.sv
verif/capability_string_unescape_unit_tb.sv
